// File: design/wlfo_pkg.sv
// Shared types and constants for the wavetable LFO modulator.
package wlfo_pkg;

    // Sample and result widths fixed by the item format
    localparam int SAMPLE_W = 16;
    localparam int MOD_W    = 24;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RATE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_VOL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_PAN = 3'd6;

    // Item actions
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // Modulation targets
    localparam logic [1:0] TGT_PITCH  = 2'd0;
    localparam logic [1:0] TGT_VOLUME = 2'd1;
    localparam logic [1:0] TGT_PAN    = 2'd2;
    localparam logic [1:0] TGT_NONE   = 2'd3;

    // Fixed-point constants
    localparam int UNITY    = 65536;     // 1.0 in Q.16
    localparam int PAN_ONE  = 65536;     // full pan in Q1.16
    localparam int PAN_COEF = 45875;     // 0.7 in Q0.16
    localparam int MOD_MAX  = 8388607;
    localparam int MOD_MIN  = -8388608;

    // Reset values of the configuration registers
    localparam logic [8:0]  LENGTH_RESET   = 9'd256;
    localparam logic [23:0] BASE_VOL_RESET = 24'd65536;

    // Tick sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PHASE,
        ST_POS,
        ST_RD0,
        ST_RD1,
        ST_INTERP,
        ST_SCALE,
        ST_PREP,
        ST_MUL2,
        ST_DONE
    } wlfo_state_t;

endpackage

// File: design/wlfo_table.sv
// Waveform sample memory: one write port, one registered read port.
module wlfo_table #(
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [wlfo_pkg::SAMPLE_W-1:0] wr_data,
    input  logic [AW-1:0]                 rd_addr,
    output logic [wlfo_pkg::SAMPLE_W-1:0] rd_data
);
    import wlfo_pkg::*;

    logic [SAMPLE_W-1:0] mem [DEPTH];

    // Store a sample
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read: the data for an address appears in the next cycle
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// File: design/wavetable_lfo_modulator.sv
// Wavetable LFO modulator: tick sequencer, interpolation and modulation math.
// A table write or a suppressed tick leaves the sequencer idle; an unused-target tick only
// advances the phase. An active tick runs phase, position, two reads through the table's
// read port, interpolation, depth scaling, rounding and a second product up to the output
// register; no new item is taken until its result is loaded, which waits on output stalls.
// Reset clears phase to zero and loads register defaults; table contents stay unknown.
module wavetable_lfo_modulator #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           cfg_write,
    input  logic [wlfo_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wlfo_pkg::CFG_W-1:0]     cfg_data,
    // input items
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           action,
    input  logic [7:0]                     table_index,
    input  logic signed [15:0]             table_value,
    input  logic [23:0]                    delta_time,
    // result items
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     target_code,
    output logic signed [23:0]             mod_value
);
    import wlfo_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int LW = $clog2(TABLE_DEPTH + 1);
    localparam int PW = 32 + LW;

    // Configuration registers
    logic [23:0]        lfo_rate_reg;
    logic [15:0]        lfo_depth_reg;
    logic [1:0]         lfo_target_reg;
    logic               lfo_enable_reg;
    logic [8:0]         table_length_reg;
    logic [23:0]        base_volume_reg;
    logic signed [17:0] base_pan_reg;

    // Sequencer and datapath
    wlfo_state_t        state_reg, state_next;
    logic [31:0]        phase_reg;
    logic [47:0]        inc_reg;
    logic [PW-1:0]      pos_reg;
    logic [AW-1:0]      i1_reg;
    logic [15:0]        frac_reg;
    logic signed [15:0] w0_reg;
    logic signed [31:0] s_reg;
    logic signed [47:0] p_reg;
    logic signed [21:0] pitch_reg;
    logic signed [24:0] mul_a_reg;
    logic signed [28:0] mul_b_reg;
    logic signed [53:0] prod2_reg;

    // Output register
    logic               out_valid_reg;
    logic [1:0]         target_code_reg;
    logic signed [23:0] mod_value_reg;

    logic               in_accept;
    logic               out_free;
    logic               out_load;
    logic               tick_go;

    // Table port signals
    logic               wr_en;
    logic [31:0]        idx_wide;
    logic [AW-1:0]      rd_addr;
    logic [15:0]        rd_data;

    // Index and length arithmetic
    logic [31:0]        len_wide;
    logic [LW-1:0]      len;
    logic [LW-1:0]      i0_raw;
    logic [LW-1:0]      i0;
    logic [LW-1:0]      i1;

    // Math intermediates
    logic signed [16:0] diff;
    logic signed [33:0] s_full;
    logic signed [47:0] pitch_sum;
    logic signed [47:0] vol_sum;
    logic signed [47:0] pan_sum;
    logic signed [20:0] pitch_q;
    logic signed [20:0] factor;
    logic signed [28:0] d24;
    logic signed [53:0] vol_round;
    logic signed [53:0] pan_round;
    logic signed [37:0] vol_r;
    logic signed [29:0] pan_r;
    logic signed [30:0] pan_v;
    logic signed [23:0] result;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign tick_go   = in_accept && (action == ACT_TICK) && lfo_enable_reg
                       && (lfo_depth_reg != 16'd0);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfo_rate_reg     <= '0;
            lfo_depth_reg    <= '0;
            lfo_target_reg   <= TGT_PITCH;
            lfo_enable_reg   <= 1'b0;
            table_length_reg <= LENGTH_RESET;
            base_volume_reg  <= BASE_VOL_RESET;
            base_pan_reg     <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_RATE:     lfo_rate_reg     <= cfg_data[23:0];
                REG_DEPTH:    lfo_depth_reg    <= cfg_data[15:0];
                REG_TARGET:   lfo_target_reg   <= cfg_data[1:0];
                REG_ENABLE:   lfo_enable_reg   <= cfg_data[0];
                REG_LENGTH:   table_length_reg <= cfg_data[8:0];
                REG_BASE_VOL: base_volume_reg  <= cfg_data[23:0];
                REG_BASE_PAN: base_pan_reg     <= $signed(cfg_data[17:0]);
                default:      ;
            endcase
        end
    end

    // Table write decode: drop indexes beyond the table
    assign idx_wide = 32'(table_index);
    assign wr_en    = in_accept && (action == ACT_WRITE)
                      && (idx_wide < 32'(TABLE_DEPTH));

    wlfo_table #(
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (idx_wide[AW-1:0]),
        .wr_data (table_value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Effective table length, limited to 1..TABLE_DEPTH
    always_comb
    begin
        if (table_length_reg == 9'd0)
        begin
            len_wide = 32'd1;
        end
        else if (32'(table_length_reg) > 32'(TABLE_DEPTH))
        begin
            len_wide = 32'(TABLE_DEPTH);
        end
        else
        begin
            len_wide = 32'(table_length_reg);
        end
    end
    assign len = len_wide[LW-1:0];

    // Neighbor indexes from the scaled phase
    assign i0_raw = pos_reg[PW-1:32];
    assign i0     = (i0_raw >= len) ? (len - LW'(1)) : i0_raw;
    assign i1     = ((i0 + LW'(1)) >= len) ? '0 : (i0 + LW'(1));

    // Interpolated sample in Q1.31
    assign diff   = 17'($signed(rd_data)) - 17'(w0_reg);
    assign s_full = (34'(w0_reg) <<< 16) + (34'(diff) * 34'($signed({1'b0, frac_reg})));

    // Rounded scalings of the depth product
    assign pitch_sum = p_reg + 48'sd67108864;
    assign vol_sum   = p_reg + 48'sd134217728;
    assign pan_sum   = p_reg + 48'sd262144;
    assign pitch_q   = $signed(pitch_sum[47:27]);
    assign factor    = 21'($signed(vol_sum[47:28])) + 21'(UNITY);
    assign d24       = $signed(pan_sum[47:19]);

    // Final rounding of the second product
    assign vol_round = prod2_reg + 54'sd32768;
    assign pan_round = prod2_reg + 54'sd8388608;
    assign vol_r     = $signed(vol_round[53:16]);
    assign pan_r     = $signed(pan_round[53:24]);
    assign pan_v     = 31'(base_pan_reg) + 31'(pan_r);

    // Select, clamp and saturate the result
    always_comb
    begin
        case (lfo_target_reg)
            TGT_VOLUME:
            begin
                if (vol_r < 0)
                begin
                    result = '0;
                end
                else if (vol_r > MOD_MAX)
                begin
                    result = 24'(MOD_MAX);
                end
                else
                begin
                    result = vol_r[23:0];
                end
            end
            TGT_PAN:
            begin
                if (pan_v > PAN_ONE)
                begin
                    result = 24'(PAN_ONE);
                end
                else if (pan_v < -PAN_ONE)
                begin
                    result = 24'(-PAN_ONE);
                end
                else
                begin
                    result = pan_v[23:0];
                end
            end
            default:
            begin
                result = 24'(pitch_reg);
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state, handshake and read address
    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        out_load   = 1'b0;
        rd_addr    = i0[AW-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (tick_go)
                begin
                    state_next = ST_PHASE;
                end
            end
            ST_PHASE:
            begin
                state_next = (lfo_target_reg == TGT_NONE) ? ST_IDLE : ST_POS;
            end
            ST_POS:
            begin
                state_next = ST_RD0;
            end
            ST_RD0:
            begin
                rd_addr    = i0[AW-1:0];
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                rd_addr    = i1_reg;
                state_next = ST_INTERP;
            end
            ST_INTERP:
            begin
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Phase accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (state_reg == ST_PHASE)
        begin
            phase_reg <= phase_reg + inc_reg[39:8];
        end
    end

    // Datapath stages
    always_ff @(posedge clk)
    begin
        if (tick_go)
        begin
            inc_reg <= 48'(lfo_rate_reg) * 48'(delta_time);
        end
        if (state_reg == ST_POS)
        begin
            pos_reg <= PW'(phase_reg) * PW'(len);
        end
        if (state_reg == ST_RD0)
        begin
            i1_reg   <= i1[AW-1:0];
            frac_reg <= pos_reg[31:16];
        end
        if (state_reg == ST_RD1)
        begin
            w0_reg <= $signed(rd_data);
        end
        if (state_reg == ST_INTERP)
        begin
            s_reg <= s_full[31:0];
        end
        if (state_reg == ST_SCALE)
        begin
            p_reg <= 48'(s_reg) * 48'($signed({1'b0, lfo_depth_reg}));
        end
        if (state_reg == ST_PREP)
        begin
            pitch_reg <= 22'(pitch_q) + 22'(UNITY);
            if (lfo_target_reg == TGT_VOLUME)
            begin
                mul_a_reg <= $signed({1'b0, base_volume_reg});
                mul_b_reg <= 29'(factor);
            end
            else
            begin
                mul_a_reg <= 25'(PAN_COEF);
                mul_b_reg <= d24;
            end
        end
        if (state_reg == ST_MUL2)
        begin
            prod2_reg <= 54'(mul_a_reg) * 54'(mul_b_reg);
        end
    end

    // Output item register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            target_code_reg <= lfo_target_reg;
            mod_value_reg   <= result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign target_code = target_code_reg;
    assign mod_value   = mod_value_reg;

    // Checks
    a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
        tick_go |=> (state_reg == ST_PHASE))
        else $error("active tick did not start the sequencer");

    a_write_keeps_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (action == ACT_WRITE)) |=> $stable(phase_reg))
        else $error("table write changed the phase");

    a_done_emits: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && out_free) |=> (out_valid_reg && (state_reg == ST_IDLE)))
        else $error("finished tick did not produce an item");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && (state_reg == ST_DONE)) |=> (state_reg == ST_DONE))
        else $error("result dropped while output was stalled");

endmodule
